// ===== design/graphics_tablet_position_counter_macros.svh =====
// Assertion macros for the graphics tablet position counter.
// Users supply clk and rst_n in scope; define ASSERT_OFF to drop the checks.
`ifndef GRAPHICS_TABLET_POSITION_COUNTER_MACROS_SVH
`define GRAPHICS_TABLET_POSITION_COUNTER_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked at every rising edge outside reset.
`define GTPC_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define GTPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define GTPC_ASSERT_IMPLY(lbl, ante, cons, msg)
`define GTPC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== design/gtpc_pkg.sv =====
// Package for the graphics tablet position counter: command codes, item type
// and the fixed constants of the drive timer and counter. No dependencies.
package gtpc_pkg;

  typedef enum logic [2:0] {
    CMD_TICK   = 3'd0,
    CMD_BUS    = 3'd1,
    CMD_PROX   = 3'd2,
    CMD_XPOS   = 3'd3,
    CMD_YPOS   = 3'd4,
    CMD_BUTTON = 3'd5,
    CMD_WINDOW = 3'd6
  } cmd_t;

  localparam logic [1:0] ADDR_DRIVE_X   = 2'd0;
  localparam logic [1:0] ADDR_DRIVE_Y   = 2'd1;
  localparam logic [1:0] ADDR_READ_LOW  = 2'd2;
  localparam logic [1:0] ADDR_READ_HIGH = 2'd3;

  localparam logic [5:0]  DRIVE_RATE  = 6'd49;
  localparam logic [11:0] DRIVE_BASE  = 12'd300;
  localparam logic [11:0] DRIVE_SCALE = 12'd2150;
  localparam logic [16:0] POS_ONE     = 17'h10000;
  localparam logic [16:0] POS_HALF    = 17'h08000;
  localparam logic [3:0]  CNT_LOW_XOR = 4'h7;

  typedef struct packed {
    logic [2:0]         command;
    logic [1:0]         address;
    logic [7:0]         bus_byte;
    logic signed [17:0] value;
  } item_t;

endpackage

// ===== design/gtpc_in_if.sv =====
// Input channel of the tablet position counter: valid/ready plus one item.
// Depends on gtpc_pkg.
interface gtpc_in_if import gtpc_pkg::*;;
  logic               valid;
  logic               ready;
  logic [2:0]         command;
  logic [1:0]         address;
  logic [7:0]         bus_byte;
  logic signed [17:0] value;

  modport source (output valid, command, address, bus_byte, value, input ready);
  modport sink   (input valid, command, address, bus_byte, value, output ready);
endinterface

// ===== design/gtpc_out_if.sv =====
// Result channel of the tablet position counter: valid/ready plus read byte.
// No dependencies.
interface gtpc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink   (input valid, read_data, output ready);
endinterface

// ===== design/gtpc_core.sv =====
// Tablet card state (proximity, positions, button, counter, drive timer)
// and its update for one item. Depends on gtpc_pkg.
module gtpc_core import gtpc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  item_t      item,
  output logic [7:0] read_data
);

  logic        in_proximity_r, in_proximity_nxt;
  logic [16:0] pos_x_r, pos_x_nxt;
  logic [16:0] pos_y_r, pos_y_nxt;
  logic        button_down_r, button_down_nxt;
  logic [11:0] counter_r, counter_nxt;
  logic [11:0] drive_remaining_r, drive_remaining_nxt;
  logic        count_enabled_r, count_enabled_nxt;

  logic [16:0] pos_clamped;
  logic [16:0] pos_sel;
  logic [28:0] drive_prod;
  logic [11:0] drive_load;
  logic [5:0]  drive_step;
  logic        flag;

  // Q1.16 position: negatives clamp to zero, anything above 1.0 to 1.0.
  always_comb begin
    if (item.value[17]) begin
      pos_clamped = '0;
    end else if (item.value[16:0] > POS_ONE) begin
      pos_clamped = POS_ONE;
    end else begin
      pos_clamped = item.value[16:0];
    end
  end

  assign flag       = (item.value != '0);
  assign pos_sel    = (item.address == ADDR_DRIVE_Y) ? pos_y_r : pos_x_r;
  assign drive_prod = 29'(pos_sel) * 29'(DRIVE_SCALE);
  // The scaled term is at most 2150, so the sum stays within 12 bits.
  assign drive_load = DRIVE_BASE + drive_prod[27:16];
  assign drive_step = (drive_remaining_r < {6'd0, DRIVE_RATE}) ?
                      drive_remaining_r[5:0] : DRIVE_RATE;

  always_comb begin
    in_proximity_nxt    = in_proximity_r;
    pos_x_nxt           = pos_x_r;
    pos_y_nxt           = pos_y_r;
    button_down_nxt     = button_down_r;
    counter_nxt         = counter_r;
    drive_remaining_nxt = drive_remaining_r;
    count_enabled_nxt   = count_enabled_r;
    read_data           = item.bus_byte;
    case (item.command)
      CMD_TICK: begin
        drive_remaining_nxt = drive_remaining_r - {6'd0, drive_step};
        if (count_enabled_r) begin
          counter_nxt = counter_r + {6'd0, drive_step};
        end
      end
      CMD_BUS: begin
        case (item.address)
          ADDR_DRIVE_X, ADDR_DRIVE_Y: begin
            if (in_proximity_r) begin
              drive_remaining_nxt = drive_load;
            end
            counter_nxt = {4'hf, counter_r[7:0]};
          end
          ADDR_READ_LOW: begin
            read_data = {item.bus_byte[7:4], counter_r[3:0] ^ CNT_LOW_XOR};
          end
          default: begin
            counter_nxt = {counter_r[11:4], 3'd0, ~button_down_r};
            read_data   = counter_r[11:4];
          end
        endcase
      end
      CMD_PROX:   in_proximity_nxt = flag;
      CMD_XPOS:   pos_x_nxt = pos_clamped;
      CMD_YPOS:   pos_y_nxt = pos_clamped;
      CMD_BUTTON: button_down_nxt = flag;
      CMD_WINDOW: begin
        count_enabled_nxt = flag;
        if (!flag) begin
          counter_nxt = {counter_r[11:8], 8'd0};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_proximity_r    <= 1'b0;
      pos_x_r           <= POS_HALF;
      pos_y_r           <= POS_HALF;
      button_down_r     <= 1'b0;
      counter_r         <= '0;
      drive_remaining_r <= '0;
      count_enabled_r   <= 1'b0;
    end else if (step) begin
      in_proximity_r    <= in_proximity_nxt;
      pos_x_r           <= pos_x_nxt;
      pos_y_r           <= pos_y_nxt;
      button_down_r     <= button_down_nxt;
      counter_r         <= counter_nxt;
      drive_remaining_r <= drive_remaining_nxt;
      count_enabled_r   <= count_enabled_nxt;
    end
  end

endmodule

// ===== design/graphics_tablet_position_counter.sv =====
// Channel  | Dir | Payload                                | Result
// in_ch    | in  | command, address, bus_byte, value      | -
// out_ch   | out | read_data                              | one per bus access
//
// An item is registered on acceptance and applied to the card state when it
// leaves that register; a bus access then leaves its byte in the output
// register. One item per cycle is sustained while the output register does
// not stall; it stalls only items that have a result. Reset is synchronous
// and clears the pipeline and the card state.
// Depends on gtpc_pkg, gtpc_in_if, gtpc_out_if, gtpc_core and the macros.
`include "graphics_tablet_position_counter_macros.svh"

module graphics_tablet_position_counter import gtpc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  gtpc_in_if.sink    in_ch,
  gtpc_out_if.source out_ch
);

  logic       s1_valid_r, s1_valid_nxt;
  item_t      s1_item_r;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_data_r;
  logic [7:0] core_read_data;
  logic       s1_has_result;
  logic       s1_adv;
  logic       in_fire;

  assign s1_has_result = (s1_item_r.command == CMD_BUS);
  assign s1_adv        = s1_valid_r && (!s1_has_result || !out_valid_r || out_ch.ready);
  assign in_ch.ready   = !s1_valid_r || s1_adv;
  assign in_fire       = in_ch.valid && in_ch.ready;

  always_comb begin
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
    if (s1_adv && s1_has_result) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.command  <= in_ch.command;
      s1_item_r.address  <= in_ch.address;
      s1_item_r.bus_byte <= in_ch.bus_byte;
      s1_item_r.value    <= in_ch.value;
    end
    if (s1_adv && s1_has_result) begin
      out_data_r <= core_read_data;
    end
  end

  gtpc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_adv),
    .item      (s1_item_r),
    .read_data (core_read_data)
  );

  assign out_ch.valid     = out_valid_r;
  assign out_ch.read_data = out_data_r;

  `GTPC_ASSERT_IMPLY(a_no_overrun, s1_valid_r && !s1_adv, !in_fire, "input taken into a stalled stage")
  `GTPC_ASSERT_NEXT(a_result_issued, s1_adv && s1_has_result, out_valid_r, "bus access lost its result")
  `GTPC_ASSERT_NEXT(a_result_held, out_valid_r && !out_ch.ready, out_valid_r && $stable(out_data_r), "pending result dropped or changed")

endmodule

// ===== test/testbench.sv =====
// Testbench for the graphics tablet position counter: a directed table, then
// random tablet events, drives and counter reads checked against a predictor.
// Depends on gtpc_pkg, gtpc_in_if, gtpc_out_if and the counter RTL.
module testbench import gtpc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] CMD_UNUSED = 3'd7;
  localparam int RANDOM_ITEMS = 450;
  localparam int HOLD_CYCLES  = 200;
  localparam int READS_BEFORE_HOLD = 20;
  localparam int CYCLE_LIMIT  = 300000;

  typedef struct packed {
    item_t      it;
    logic       typed;
    logic [7:0] want;
  } plan_row_t;

  // Rows with typed set carry a read byte that follows directly from reset
  // or from a drive; the rest are predicted.
  localparam plan_row_t PLAN [0:23] = '{
    '{'{CMD_BUS,    ADDR_READ_LOW,  8'h00, 18'sd0},       1'b1, 8'h07},
    '{'{CMD_BUS,    ADDR_READ_HIGH, 8'h00, 18'sd0},       1'b1, 8'h00},
    '{'{CMD_BUS,    ADDR_READ_LOW,  8'hff, 18'sh3ffff},   1'b1, 8'hf6},
    '{'{CMD_BUS,    ADDR_DRIVE_X,   8'ha5, 18'sd0},       1'b1, 8'ha5},
    '{'{CMD_BUS,    ADDR_READ_HIGH, 8'h3c, 18'sd0},       1'b1, 8'hf0},
    '{'{CMD_UNUSED, ADDR_READ_HIGH, 8'hff, 18'sh1ffff},   1'b0, 8'h00},
    '{'{CMD_PROX,   ADDR_DRIVE_X,   8'h00, 18'sd1},       1'b0, 8'h00},
    '{'{CMD_XPOS,   ADDR_DRIVE_X,   8'h00, 18'sh20000},   1'b0, 8'h00},
    '{'{CMD_YPOS,   ADDR_DRIVE_X,   8'h00, 18'sh1ffff},   1'b0, 8'h00},
    '{'{CMD_WINDOW, ADDR_DRIVE_X,   8'h00, 18'sd1},       1'b0, 8'h00},
    '{'{CMD_BUS,    ADDR_DRIVE_X,   8'h5a, 18'sd0},       1'b1, 8'h5a},
    '{'{CMD_TICK,   ADDR_READ_HIGH, 8'hff, 18'sh3ffff},   1'b0, 8'h00},
    '{'{CMD_TICK,   ADDR_DRIVE_X,   8'h00, 18'sd0},       1'b0, 8'h00},
    '{'{CMD_TICK,   ADDR_DRIVE_Y,   8'h81, 18'sh2aaaa},   1'b0, 8'h00},
    '{'{CMD_BUS,    ADDR_READ_LOW,  8'h00, 18'sd0},       1'b0, 8'h00},
    '{'{CMD_BUTTON, ADDR_DRIVE_X,   8'h00, 18'sh20000},   1'b0, 8'h00},
    '{'{CMD_BUS,    ADDR_READ_HIGH, 8'h00, 18'sd0},       1'b0, 8'h00},
    '{'{CMD_WINDOW, ADDR_DRIVE_X,   8'h00, 18'sd0},       1'b0, 8'h00},
    '{'{CMD_BUS,    ADDR_DRIVE_Y,   8'hff, 18'sd0},       1'b1, 8'hff},
    '{'{CMD_TICK,   ADDR_DRIVE_X,   8'h00, 18'sd0},       1'b0, 8'h00},
    '{'{CMD_BUS,    ADDR_READ_LOW,  8'h0f, 18'sd0},       1'b0, 8'h00},
    '{'{CMD_XPOS,   ADDR_DRIVE_X,   8'h00, 18'sh10001},   1'b0, 8'h00},
    '{'{CMD_PROX,   ADDR_DRIVE_X,   8'h00, 18'sd0},       1'b0, 8'h00},
    '{'{CMD_BUS,    ADDR_DRIVE_X,   8'h00, 18'sd0},       1'b1, 8'h00}
  };

  logic clk;
  logic rst_n;

  gtpc_in_if  in_ch ();
  gtpc_out_if out_ch ();

  graphics_tablet_position_counter dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predicted card state.
  logic        card_prox;
  logic [16:0] card_pos_x;
  logic [16:0] card_pos_y;
  logic        card_button;
  logic [11:0] card_count;
  logic [11:0] card_drive;
  logic        card_enabled;

  logic [7:0] pending_reads[$];
  int         errors;
  int         items_sent;
  int         reads_seen;
  int         ticks_sent;
  int         cycle_count;
  bit         receiver_held;
  bit         steady;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [16:0] clamp_position(input logic signed [17:0] raw);
    int v;
    v = $signed(raw);
    if (v < 0) return 17'd0;
    if (v > int'(POS_ONE)) return POS_ONE;
    return 17'(v);
  endfunction

  function automatic void apply_to_card(input item_t it, output bit has_read,
                                        output logic [7:0] rd);
    logic [11:0] step;
    logic [16:0] pos;
    has_read = 1'b0;
    rd = 8'h00;
    case (it.command)
      CMD_TICK: begin
        step = (card_drive < 12'(DRIVE_RATE)) ? card_drive : 12'(DRIVE_RATE);
        card_drive = card_drive - step;
        if (card_enabled) card_count = card_count + step;
      end
      CMD_BUS: begin
        has_read = 1'b1;
        case (it.address)
          ADDR_DRIVE_X, ADDR_DRIVE_Y: begin
            pos = (it.address == ADDR_DRIVE_X) ? card_pos_x : card_pos_y;
            if (card_prox)
              card_drive = 12'(32'(DRIVE_BASE) + ((32'(DRIVE_SCALE) * 32'(pos)) >> 16));
            card_count = card_count | 12'hf00;
            rd = it.bus_byte;
          end
          ADDR_READ_LOW: begin
            rd = {it.bus_byte[7:4], card_count[3:0] ^ CNT_LOW_XOR};
          end
          default: begin
            card_count = {card_count[11:4], 3'b000, ~card_button};
            rd = card_count[11:4];
          end
        endcase
      end
      CMD_PROX:   card_prox = (it.value != 18'sd0);
      CMD_XPOS:   card_pos_x = clamp_position(it.value);
      CMD_YPOS:   card_pos_y = clamp_position(it.value);
      CMD_BUTTON: card_button = (it.value != 18'sd0);
      CMD_WINDOW: begin
        card_enabled = (it.value != 18'sd0);
        if (!card_enabled) card_count = card_count & 12'hf00;
      end
      default: ;
    endcase
  endfunction

  // Mostly short gaps, a few long ones, none at all during steady stretches.
  function automatic int idle_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  function automatic logic signed [17:0] position_value();
    case ($urandom_range(0, 4))
      0: return 18'($urandom);
      1: return 18'($urandom_range(0, 65536));
      2: return 18'($urandom_range(65535, 65537));
      3: return 18'(-int'($urandom_range(1, 131072)));
      default: return 18'($urandom_range(65537, 131071));
    endcase
  endfunction

  function automatic item_t make_item(input logic [2:0] cmd);
    item_t it;
    it.command  = cmd;
    it.address  = 2'($urandom);
    it.bus_byte = 8'($urandom);
    it.value    = 18'($urandom);
    if (cmd == CMD_XPOS || cmd == CMD_YPOS)
      it.value = position_value();
    else if ($urandom_range(0, 2) == 0)
      it.value = 18'sd0;
    return it;
  endfunction

  function automatic item_t random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return make_item(CMD_TICK);
    if (r < 60) return make_item(CMD_BUS);
    if (r < 68) return make_item(CMD_PROX);
    if (r < 76) return make_item(CMD_XPOS);
    if (r < 84) return make_item(CMD_YPOS);
    if (r < 90) return make_item(CMD_BUTTON);
    if (r < 97) return make_item(CMD_WINDOW);
    return make_item(CMD_UNUSED);
  endfunction

  task automatic offer(input item_t it, input logic typed, input logic [7:0] want);
    bit         has_read;
    logic [7:0] rd;
    int         gap;
    in_ch.valid    <= 1'b1;
    in_ch.command  <= it.command;
    in_ch.address  <= it.address;
    in_ch.bus_byte <= it.bus_byte;
    in_ch.value    <= it.value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    apply_to_card(it, has_read, rd);
    if (has_read) pending_reads.push_back(typed ? want : rd);
    if (it.command != CMD_UNUSED) items_sent++;
    if (it.command == CMD_TICK) ticks_sent++;
    gap = idle_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Typical measurement: pen mostly in range, window open, a drive started,
  // then ticks, both counter reads and sometimes a window close.
  task automatic measure_position();
    item_t it;
    it = make_item(CMD_PROX);
    it.value = ($urandom_range(0, 4) == 0) ? 18'sd0 : 18'($urandom_range(1, 262143));
    offer(it, 1'b0, 8'h00);
    it = make_item($urandom_range(0, 1) ? CMD_XPOS : CMD_YPOS);
    it.value = 18'($urandom_range(0, 65536));
    offer(it, 1'b0, 8'h00);
    it = make_item(CMD_WINDOW);
    it.value = 18'($urandom_range(1, 262143));
    offer(it, 1'b0, 8'h00);
    it = make_item(CMD_BUS);
    it.address = $urandom_range(0, 1) ? ADDR_DRIVE_Y : ADDR_DRIVE_X;
    offer(it, 1'b0, 8'h00);
    repeat ($urandom_range(1, 60)) offer(make_item(CMD_TICK), 1'b0, 8'h00);
    it = make_item(CMD_BUS);
    it.address = ADDR_READ_LOW;
    offer(it, 1'b0, 8'h00);
    it.address = ADDR_READ_HIGH;
    offer(it, 1'b0, 8'h00);
    if ($urandom_range(0, 1)) begin
      it = make_item(CMD_WINDOW);
      it.value = 18'sd0;
      offer(it, 1'b0, 8'h00);
    end
  endtask

  task automatic drain_reads();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_reads.size() != 0);
  endtask

  initial begin
    int  start;
    bit  paused;
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.command  <= CMD_TICK;
    in_ch.address  <= ADDR_DRIVE_X;
    in_ch.bus_byte <= 8'h00;
    in_ch.value    <= 18'sd0;
    card_prox    = 1'b0;
    card_pos_x   = POS_HALF;
    card_pos_y   = POS_HALF;
    card_button  = 1'b0;
    card_count   = 12'h000;
    card_drive   = 12'h000;
    card_enabled = 1'b0;
    paused = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (PLAN[i]) offer(PLAN[i].it, PLAN[i].typed, PLAN[i].want);

    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      // Once, halfway through, let every pending read come back first.
      if (!paused && items_sent - start >= RANDOM_ITEMS / 2) begin
        drain_reads();
        paused = 1'b1;
      end
      if ($urandom_range(0, 5) == 0)
        measure_position();
      else
        offer(random_item(), 1'b0, 8'h00);
    end

    drain_reads();
    repeat (8) @(posedge clk);
    $display("Covered %0d items (%0d ticks) and checked %0d bus reads.",
             items_sent, ticks_sent, reads_seen);
    $display("The result side held off for %0d cycles once; %0d mismatches.",
             HOLD_CYCLES, errors);
    if (errors == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

  // Result side: random ready with one long hold-off while input keeps coming.
  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    receiver_held = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!receiver_held && reads_seen >= READS_BEFORE_HOLD) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        receiver_held = 1'b1;
      end else begin
        gap = idle_gap();
        if (gap == 0) begin
          out_ch.ready <= 1'b1;
          @(posedge clk);
        end else begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  initial begin
    steady = 1'b0;
    forever begin
      repeat ($urandom_range(50, 300)) @(negedge clk);
      steady = ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_reads.size() == 0) begin
        $error("read_data 0x%02h arrived with no bus access outstanding",
               out_ch.read_data);
        errors++;
      end else begin
        if (out_ch.read_data !== pending_reads[0]) begin
          $error("read_data mismatch: expected 0x%02h, got 0x%02h",
                 pending_reads[0], out_ch.read_data);
          errors++;
        end
        void'(pending_reads.pop_front());
        reads_seen++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

endmodule
